>>> sv/q2e_pkg.sv
// Shared constants, types and the arctangent table of the quaternion to Euler core.
// No dependencies; every other file of the block imports this package.
package q2e_pkg;

  localparam int COMPONENT_BITS = 16;
  localparam int CORDIC_STEPS   = 16;

  localparam int FRAC_BITS       = COMPONENT_BITS - 1;
  localparam int PROD_BITS       = 2 * COMPONENT_BITS;
  localparam int PROD_SHIFT_DOWN = (2 * FRAC_BITS >= 30) ? (2 * FRAC_BITS - 30) : 0;
  localparam int PROD_SHIFT_UP   = (2 * FRAC_BITS >= 30) ? 0 : (30 - 2 * FRAC_BITS);

  // Q.30 terms: one product fits 32 bits, doubled sums need 34
  localparam int TERM_BITS = 34;
  localparam int S_BITS    = 32;

  localparam int SQRT_STEPS = 31;
  localparam int RAD_BITS   = 2 * SQRT_STEPS;
  localparam int ROOT_BITS  = SQRT_STEPS;
  localparam int REM_BITS   = ROOT_BITS + 4;

  localparam int TABLE_LEN    = 32;
  localparam int CORDIC_ITERS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int CW           = TERM_BITS + 4;
  localparam int LANES        = 3;
  localparam int LANE_ROLL    = 0;
  localparam int LANE_PITCH   = 1;
  localparam int LANE_YAW     = 2;

  localparam logic [31:0] ATAN_TABLE [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic signed [TERM_BITS-1:0] sr;
    logic signed [TERM_BITS-1:0] cr;
    logic signed [TERM_BITS-1:0] sy;
    logic signed [TERM_BITS-1:0] cy;
    logic                        clamped;
  } side_t;

endpackage

>>> sv/q2e_terms.sv
// Product and sum stages: quaternion components to Q.30 atan2 operands and pitch sine.
// Depends on q2e_pkg.
module q2e_terms import q2e_pkg::*; (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic signed [COMPONENT_BITS-1:0] qw_i,
  input  logic signed [COMPONENT_BITS-1:0] qx_i,
  input  logic signed [COMPONENT_BITS-1:0] qy_i,
  input  logic signed [COMPONENT_BITS-1:0] qz_i,
  output logic                             valid_o,
  output side_t                            side_o,
  output logic signed [S_BITS-1:0]         s_o
);

  localparam int NPROD = 9;
  localparam int P_WX = 0, P_YZ = 1, P_XX = 2, P_YY = 3, P_WZ = 4, P_XY = 5,
                 P_ZZ = 6, P_WY = 7, P_XZ = 8;
  localparam logic signed [TERM_BITS-1:0] ONE_Q30 = TERM_BITS'(64'sd1 << 30);

  logic signed [PROD_BITS-1:0] raw_d  [NPROD];
  logic signed [TERM_BITS-1:0] prod_d [NPROD];
  logic signed [TERM_BITS-1:0] prod_q [NPROD];
  logic                        v1_q, v2_q;
  side_t                       side_d, side_q;
  logic signed [TERM_BITS-1:0] s_raw;
  logic signed [S_BITS-1:0]    s_d, s_q;

  always_comb begin
    raw_d[P_WX] = qw_i * qx_i;
    raw_d[P_YZ] = qy_i * qz_i;
    raw_d[P_XX] = qx_i * qx_i;
    raw_d[P_YY] = qy_i * qy_i;
    raw_d[P_WZ] = qw_i * qz_i;
    raw_d[P_XY] = qx_i * qy_i;
    raw_d[P_ZZ] = qz_i * qz_i;
    raw_d[P_WY] = qw_i * qy_i;
    raw_d[P_XZ] = qx_i * qz_i;
    for (int i = 0; i < NPROD; i++) begin
      prod_d[i] = TERM_BITS'(raw_d[i] >>> PROD_SHIFT_DOWN) <<< PROD_SHIFT_UP;
    end
  end

  always_comb begin
    side_d.sr = (prod_q[P_WX] + prod_q[P_YZ]) <<< 1;
    side_d.cr = ONE_Q30 - ((prod_q[P_XX] + prod_q[P_YY]) <<< 1);
    side_d.sy = (prod_q[P_WZ] + prod_q[P_XY]) <<< 1;
    side_d.cy = ONE_Q30 - ((prod_q[P_YY] + prod_q[P_ZZ]) <<< 1);
    s_raw     = (prod_q[P_WY] - prod_q[P_XZ]) <<< 1;
    side_d.clamped = 1'b0;
    if (s_raw > ONE_Q30) begin
      s_d = S_BITS'(ONE_Q30);
      side_d.clamped = 1'b1;
    end else if (s_raw < -ONE_Q30) begin
      s_d = S_BITS'(-ONE_Q30);
      side_d.clamped = 1'b1;
    end else begin
      s_d = S_BITS'(s_raw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    side_q <= side_d;
    s_q    <= s_d;
  end

  assign valid_o = v2_q;
  assign side_o  = side_q;
  assign s_o     = s_q;

endmodule

>>> sv/q2e_sqrt.sv
// Pipelined digit-by-digit floor square roots of (1+s) and (1-s) in Q.30, one root bit per stage.
// Depends on q2e_pkg.
module q2e_sqrt import q2e_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic signed [S_BITS-1:0] s_i,
  output logic                     valid_o,
  output logic [ROOT_BITS-1:0]     rp_o,
  output logic [ROOT_BITS-1:0]     rm_o
);

  localparam logic signed [S_BITS:0] ONE_Q30 = (S_BITS+1)'(64'sd1 << 30);

  logic [RAD_BITS-1:0]  rad_in [2];
  logic [RAD_BITS-1:0]  rad_d  [SQRT_STEPS][2];
  logic [REM_BITS-1:0]  rem_d  [SQRT_STEPS][2];
  logic [ROOT_BITS-1:0] root_d [SQRT_STEPS][2];
  logic [RAD_BITS-1:0]  rad_q  [SQRT_STEPS][2];
  logic [REM_BITS-1:0]  rem_q  [SQRT_STEPS][2];
  logic [ROOT_BITS-1:0] root_q [SQRT_STEPS][2];
  logic                 vld_q  [SQRT_STEPS];

  always_comb begin
    logic [RAD_BITS-1:0]  rad;
    logic [REM_BITS-1:0]  rem, trial;
    logic [ROOT_BITS-1:0] root;
    logic signed [S_BITS:0] sum_p, sum_m;
    sum_p = ONE_Q30 + (S_BITS+1)'(s_i);
    sum_m = ONE_Q30 - (S_BITS+1)'(s_i);
    rad_in[0] = RAD_BITS'(sum_p) << 30;
    rad_in[1] = RAD_BITS'(sum_m) << 30;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      for (int l = 0; l < 2; l++) begin
        if (k == 0) begin
          rad  = rad_in[l];
          rem  = '0;
          root = '0;
        end else begin
          rad  = rad_q[k-1][l];
          rem  = rem_q[k-1][l];
          root = root_q[k-1][l];
        end
        rem   = {rem[REM_BITS-3:0], rad[RAD_BITS-1 -: 2]};
        trial = REM_BITS'({root, 2'b01});
        if (rem >= trial) begin
          rem  = rem - trial;
          root = {root[ROOT_BITS-2:0], 1'b1};
        end else begin
          root = {root[ROOT_BITS-2:0], 1'b0};
        end
        rad_d[k][l]  = rad << 2;
        rem_d[k][l]  = rem;
        root_d[k][l] = root;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SQRT_STEPS; k++) vld_q[k] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int k = 1; k < SQRT_STEPS; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign valid_o = vld_q[SQRT_STEPS-1];
  assign rp_o    = root_q[SQRT_STEPS-1][0];
  assign rm_o    = root_q[SQRT_STEPS-1][1];

endmodule

>>> sv/q2e_cordic.sv
// Three-lane vectoring CORDIC pipeline: one iteration per stage, 32-bit binary angle out.
// Depends on q2e_pkg.
module q2e_cordic import q2e_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic                 tag_i,
  input  logic signed [CW-1:0] x_i [LANES],
  input  logic signed [CW-1:0] y_i [LANES],
  output logic                 valid_o,
  output logic                 tag_o,
  output logic [31:0]          z_o [LANES]
);

  localparam int NST = CORDIC_ITERS + 1;

  logic signed [CW-1:0] x_d [NST][LANES];
  logic signed [CW-1:0] y_d [NST][LANES];
  logic [31:0]          z_d [NST][LANES];
  logic signed [CW-1:0] x_q [NST][LANES];
  logic signed [CW-1:0] y_q [NST][LANES];
  logic [31:0]          z_q [NST][LANES];
  logic                 tag_q [NST];
  logic                 vld_q [NST];

  always_comb begin
    logic signed [CW-1:0] xs, ys;
    for (int l = 0; l < LANES; l++) begin
      // turn a left half-plane vector by pi first
      if (x_i[l] < 0) begin
        x_d[0][l] = -x_i[l];
        y_d[0][l] = -y_i[l];
        z_d[0][l] = 32'h8000_0000;
      end else begin
        x_d[0][l] = x_i[l];
        y_d[0][l] = y_i[l];
        z_d[0][l] = '0;
      end
    end
    for (int k = 1; k < NST; k++) begin
      for (int l = 0; l < LANES; l++) begin
        xs = x_q[k-1][l] >>> (k - 1);
        ys = y_q[k-1][l] >>> (k - 1);
        x_d[k][l] = x_q[k-1][l];
        y_d[k][l] = y_q[k-1][l];
        z_d[k][l] = z_q[k-1][l];
        if (y_q[k-1][l] > 0) begin
          x_d[k][l] = x_q[k-1][l] + ys;
          y_d[k][l] = y_q[k-1][l] - xs;
          z_d[k][l] = z_q[k-1][l] + ATAN_TABLE[k-1];
        end else if (y_q[k-1][l] < 0) begin
          x_d[k][l] = x_q[k-1][l] - ys;
          y_d[k][l] = y_q[k-1][l] + xs;
          z_d[k][l] = z_q[k-1][l] - ATAN_TABLE[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) vld_q[k] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int k = 1; k < NST; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    tag_q[0] <= tag_i;
    for (int k = 1; k < NST; k++) tag_q[k] <= tag_q[k-1];
  end

  assign valid_o = vld_q[NST-1];
  assign tag_o   = tag_q[NST-1];
  assign z_o     = z_q[NST-1];

endmodule

>>> sv/quaternion_to_euler_core.sv
// Top level of the quaternion to ZYX Euler angle converter.
// Depends on q2e_pkg, q2e_terms, q2e_sqrt and q2e_cordic.
//
// A quaternion (w, x, y, z, Q1.15) is transferred in when start_i is high; busy_o is
// always low, so a new quaternion may be presented on every clock cycle. Each one
// produces exactly one result, shown on roll_o, pitch_o, yaw_o and pitch_clamped_o for
// a single cycle while valid_o is high; the receiver must take it then, as nothing
// waits. In order, the pipeline has the product and sum registers, the digit-by-digit
// square roots feeding the pitch term (one root bit per stage), one pre-rotation plus
// 16 CORDIC iterations, and an output rounding stage. Roll and yaw operands wait in a
// delay line alongside the roots so that all three angles leave together. Angles are
// binary: 32768 is pi.
module quaternion_to_euler_core import q2e_pkg::*; (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic signed [COMPONENT_BITS-1:0] qw_i,
  input  logic signed [COMPONENT_BITS-1:0] qx_i,
  input  logic signed [COMPONENT_BITS-1:0] qy_i,
  input  logic signed [COMPONENT_BITS-1:0] qz_i,
  output logic                             valid_o,
  output logic signed [15:0]               roll_o,
  output logic signed [15:0]               pitch_o,
  output logic signed [15:0]               yaw_o,
  output logic                             pitch_clamped_o
);

  localparam int PW = 35;
  localparam logic signed [PW-1:0] PITCH_BIAS = PW'((64'sd1 << 15) - (64'sd1 << 30));
  localparam logic signed [18:0]   PITCH_MAX  = 19'sd16384;

  logic                     t_valid, s_valid, c_valid, c_tag;
  side_t                    t_side;
  logic signed [S_BITS-1:0] t_s;
  logic [ROOT_BITS-1:0]     rp, rm;
  side_t                    dly_q [SQRT_STEPS];
  logic signed [CW-1:0]     cx [LANES];
  logic signed [CW-1:0]     cy [LANES];
  logic [31:0]              cz [LANES];
  logic [31:0]              roll_z, yaw_z;
  logic signed [PW-1:0]     p_full;
  logic signed [18:0]       p_round;
  logic signed [15:0]       roll_d, pitch_d, yaw_d;
  logic signed [15:0]       roll_q, pitch_q, yaw_q;
  logic                     clamp_q, valid_q;

  // Never stall: every stage advances each cycle
  assign busy_o = 1'b0;

  q2e_terms u_terms (
    .clk_i, .rst_ni,
    .valid_i (start_i),
    .qw_i, .qx_i, .qy_i, .qz_i,
    .valid_o (t_valid),
    .side_o  (t_side),
    .s_o     (t_s)
  );

  q2e_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .valid_i (t_valid),
    .s_i     (t_s),
    .valid_o (s_valid),
    .rp_o    (rp),
    .rm_o    (rm)
  );

  // Hold the roll and yaw operands for the length of the root pipeline
  always_ff @(posedge clk_i) begin
    dly_q[0] <= t_side;
    for (int k = 1; k < SQRT_STEPS; k++) dly_q[k] <= dly_q[k-1];
  end

  always_comb begin
    cy[LANE_ROLL]  = CW'(dly_q[SQRT_STEPS-1].sr);
    cx[LANE_ROLL]  = CW'(dly_q[SQRT_STEPS-1].cr);
    cy[LANE_YAW]   = CW'(dly_q[SQRT_STEPS-1].sy);
    cx[LANE_YAW]   = CW'(dly_q[SQRT_STEPS-1].cy);
    // pitch is 2*atan2(sqrt(1+s), sqrt(1-s)) - pi/2
    cy[LANE_PITCH] = CW'({1'b0, rp});
    cx[LANE_PITCH] = CW'({1'b0, rm});
  end

  q2e_cordic u_cordic (
    .clk_i, .rst_ni,
    .valid_i (s_valid),
    .tag_i   (dly_q[SQRT_STEPS-1].clamped),
    .x_i     (cx),
    .y_i     (cy),
    .valid_o (c_valid),
    .tag_o   (c_tag),
    .z_o     (cz)
  );

  // Round half up to 16 bits with wrap, and limit pitch to plus or minus pi/2
  always_comb begin
    roll_z  = cz[LANE_ROLL] + 32'h0000_8000;
    yaw_z   = cz[LANE_YAW] + 32'h0000_8000;
    roll_d  = roll_z[31:16];
    yaw_d   = yaw_z[31:16];
    p_full  = PW'({2'b00, cz[LANE_PITCH], 1'b0}) + PITCH_BIAS;
    p_round = p_full[PW-1:16];
    if (p_round > PITCH_MAX) begin
      pitch_d = PITCH_MAX[15:0];
    end else if (p_round < -PITCH_MAX) begin
      pitch_d = 16'(-PITCH_MAX);
    end else begin
      pitch_d = p_round[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= c_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    roll_q  <= roll_d;
    pitch_q <= pitch_d;
    yaw_q   <= yaw_d;
    clamp_q <= c_tag;
  end

  assign valid_o         = valid_q;
  assign roll_o          = roll_q;
  assign pitch_o         = pitch_q;
  assign yaw_o           = yaw_q;
  assign pitch_clamped_o = clamp_q;

endmodule

>>> test/quaternion_to_euler_core_tb.sv
// Self-checking bench for quaternion_to_euler_core: predicts roll, pitch and yaw in fixed point.
// Depends on q2e_pkg and the core; drives directed quaternions, then random bursts, and checks each result.
module quaternion_to_euler_core_tb;
  import q2e_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic               clamped;
  } angles_t;

  // Arithmetic shift right rounding toward minus infinity.
  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint prod_q30(longint a, longint b);
    return floor_shift(a * b, PROD_SHIFT_DOWN) <<< PROD_SHIFT_UP;
  endfunction

  function automatic longint floor_root(longint unsigned v);
    longint unsigned acc, bitv;
    acc = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= acc + bitv) begin
        v -= acc + bitv;
        acc = (acc >> 1) + bitv;
      end else begin
        acc >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(acc);
  endfunction

  function automatic logic [31:0] vector_angle(longint yv, longint xv);
    logic [31:0] z;
    longint xs, ys;
    z = 0;
    if (xv < 0) begin
      xv = -xv;
      yv = -yv;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      xs = floor_shift(xv, i);
      ys = floor_shift(yv, i);
      if (yv > 0) begin
        xv = xv + ys;
        yv = yv - xs;
        z += ATAN_TABLE[i];
      end else if (yv < 0) begin
        xv = xv - ys;
        yv = yv + xs;
        z -= ATAN_TABLE[i];
      end
    end
    return z;
  endfunction

  function automatic logic [15:0] to_bam16(logic [31:0] z);
    logic [31:0] r;
    r = z + 32'h8000;
    return r[31:16];
  endfunction

  function automatic angles_t euler_of(longint w, longint x, longint y, longint z);
    angles_t a;
    longint sr, cr, sy, cy, s, p, one;
    longint rp, rm;
    one = 64'sd1 << 30;
    sr = 2 * (prod_q30(w, x) + prod_q30(y, z));
    cr = one - 2 * (prod_q30(x, x) + prod_q30(y, y));
    sy = 2 * (prod_q30(w, z) + prod_q30(x, y));
    cy = one - 2 * (prod_q30(y, y) + prod_q30(z, z));
    s = 2 * (prod_q30(w, y) - prod_q30(x, z));
    a.clamped = 1'b0;
    if (s > one) begin
      s = one;
      a.clamped = 1'b1;
    end else if (s < -one) begin
      s = -one;
      a.clamped = 1'b1;
    end
    rp = floor_root(longint'(one + s) << 30);
    rm = floor_root(longint'(one - s) << 30);
    p = 2 * longint'({32'd0, vector_angle(rp, rm)}) - one;
    p = floor_shift(p + 64'sd32768, 16);
    if (p > 16384) p = 16384;
    if (p < -16384) p = -16384;
    a.pitch = p[15:0];
    a.roll = to_bam16(vector_angle(sr, cr));
    a.yaw = to_bam16(vector_angle(sy, cy));
    return a;
  endfunction

  class angle_scoreboard;
    angles_t pending[$];
    int errors;

    function void note_quaternion(logic signed [15:0] w, x, y, z);
      pending.push_back(euler_of(w, x, y, z));
    endfunction

    function void check_angles(angles_t got);
      angles_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result roll=%0d pitch=%0d yaw=%0d",
                                   got.roll, got.pitch, got.yaw);
        return;
      end
      exp = pending.pop_front();
      if (got.roll !== exp.roll || got.pitch !== exp.pitch || got.yaw !== exp.yaw ||
          got.clamped !== exp.clamped) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp r/p/y/c=%0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                   exp.roll, exp.pitch, exp.yaw, exp.clamped,
                   got.roll, got.pitch, got.yaw, got.clamped);
      end
    endfunction
  endclass

  logic clk_i, rst_ni, start_i, busy_o, valid_o, pitch_clamped_o;
  logic signed [COMPONENT_BITS-1:0] qw_i, qx_i, qy_i, qz_i;
  logic signed [15:0] roll_o, pitch_o, yaw_o;

  angle_scoreboard sb;
  int cycles;

  quaternion_to_euler_core dut (.*);

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: report a failure and stop the run once the cycle counter passes its limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Results cannot be held off, so sample every edge at which the strobe is up.
  always @(posedge clk_i)
    if (rst_ni && valid_o)
      sb.check_angles('{roll_o, pitch_o, yaw_o, pitch_clamped_o});

  // Hold the quaternion until a transfer happens, then drop start unless told to keep it.
  task automatic send_quaternion(logic signed [15:0] w, x, y, z, bit keep);
    start_i <= 1'b1;
    qw_i <= w;
    qx_i <= x;
    qy_i <= y;
    qz_i <= z;
    do @(posedge clk_i); while (busy_o);
    sb.note_quaternion(w, x, y, z);
    if (!keep) start_i <= 1'b0;
  endtask

  // Build a quaternion from halved random components, a gimbal-lock case, or pure noise now and then.
  task automatic random_quaternion(output logic signed [15:0] w, x, y, z);
    int c;
    c = $urandom_range(0, 9);
    w = 16'($urandom);
    x = 16'($urandom);
    y = 16'($urandom);
    z = 16'($urandom);
    if (c < 6) begin
      // halve the components so that the sum of squares stays at most one
      w = w >>> 1;
      x = x >>> 1;
      y = y >>> 1;
      z = z >>> 1;
    end else if (c < 8) begin
      // gimbal-lock neighbourhood: w close to y or to -y, x and z small
      y = w;
      if ($urandom_range(0, 1)) y = -w;
      y = 16'(y + $signed($urandom_range(0, 63)) - 32);
      x = x >>> $urandom_range(8, 15);
      z = z >>> $urandom_range(8, 15);
    end
  endtask

  localparam logic signed [15:0] MAXV = 16'sh7fff, MINV = -16'sh8000, HALF = 16'sh4000;

  initial begin
    logic signed [15:0] w, x, y, z;
    int burst;
    int gap;
    sb = new();
    cycles = 0;
    rst_ni = 0;
    start_i = 0;
    qw_i = 0;
    qx_i = 0;
    qy_i = 0;
    qz_i = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: identity, extremes, axis rotations, gimbal lock both ways,
    // and out-of-range pitch sine on non-unit inputs.
    send_quaternion(MAXV, 0, 0, 0, 1);
    send_quaternion(MINV, 0, 0, 0, 1);
    send_quaternion(0, 0, 0, 0, 1);
    send_quaternion(0, MAXV, 0, 0, 1);
    send_quaternion(0, 0, MAXV, 0, 1);
    send_quaternion(0, 0, 0, MAXV, 1);
    send_quaternion(0, MINV, 0, 0, 1);
    send_quaternion(HALF, HALF, HALF, HALF, 1);
    send_quaternion(HALF, -HALF, HALF, -HALF, 1);
    send_quaternion(HALF, 0, HALF, 0, 1);
    send_quaternion(HALF, 0, -HALF, 0, 1);
    send_quaternion(MAXV, MAXV, MAXV, MAXV, 1);
    send_quaternion(MINV, MINV, MINV, MINV, 1);
    send_quaternion(MAXV, MINV, MAXV, MINV, 1);
    send_quaternion(MINV, MAXV, MINV, MAXV, 1);
    send_quaternion(MAXV, 0, MAXV, 0, 1);
    send_quaternion(MAXV, 0, MINV, 0, 1);
    send_quaternion(16'sh5a82, 16'sh5a82, 0, 0, 1);
    send_quaternion(16'sh5a82, 0, 0, -16'sh5a82, 1);
    send_quaternion(16'sh0001, 16'shffff, 16'sh0001, 16'shffff, 1);

    // Keep start high across a burst boundary when no gap follows, and drop it
    // after the last quaternion.
    for (int n = 0; n < 700; ) begin
      burst = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 60) : 0;
      for (int b = 0; b < burst && n < 700; b++, n++) begin
        random_quaternion(w, x, y, z);
        send_quaternion(w, x, y, z, (n + 1 < 700) && ((b + 1 < burst) || (gap == 0)));
      end
      repeat (gap) @(posedge clk_i);
    end

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
